// ----- design/assert_macros.svh -----
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/gmig_pkg.sv -----
// shared types and constants of the grid mesh index generator
package gmig_pkg;

  localparam int unsigned IDX_W       = 16;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TOPOLOGY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE  = 3'd5;

  localparam logic [SLOT_W-1:0] SLOT_0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_3 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_4 = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_5 = 3'd5;

  localparam logic MODE_STRIP = 1'b0;
  localparam logic MODE_LIST  = 1'b1;

  typedef struct packed {
    logic             topology_mode;
    logic [IDX_W-1:0] columns;
    logic [IDX_W-1:0] rows;
    logic [IDX_W-1:0] column_step;
    logic [IDX_W-1:0] line_step;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             final_index;
    logic             exhausted;
  } result_t;

endpackage

// ----- design/gmig_fifo.sv -----
// small first-in first-out queue used on both sides of the generator
module gmig_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = gmig_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import gmig_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/gmig_gen.sv -----
// back end: grid walk counters and index selection, one index per step
module gmig_gen (
  input  logic             clk,
  input  logic             rst,
  input  gmig_pkg::cfg_t   cfg,
  input  logic             in_valid,
  input  logic             restart,
  output logic             in_pop,
  input  logic             out_ready,
  output logic             out_push,
  output gmig_pkg::result_t result
);
  import gmig_pkg::*;

  logic [IDX_W-1:0]  row_count, row_count_next;
  logic [IDX_W-1:0]  column_count, column_count_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [IDX_W-1:0]  row_start_vertex, row_start_vertex_next;
  logic [IDX_W-1:0]  current_vertex, current_vertex_next;
  logic              finished, finished_next;

  logic              step;
  logic [IDX_W-1:0]  c_rc, c_cc, c_rsv, c_cur;
  logic [SLOT_W-1:0] c_slot;
  logic              c_fin;
  logic [IDX_W-1:0]  cur_ls, rsv_ls, cur_cs, cur_1, cur_1_ls;
  logic              col_end_strip, col_end_list, row_end, degenerate;

  assign step     = in_valid && out_ready;
  assign in_pop   = step;
  assign out_push = step;

  // restart clears the walk before this beat is served
  assign c_rc   = restart ? '0 : row_count;
  assign c_cc   = restart ? '0 : column_count;
  assign c_slot = restart ? '0 : slot;
  assign c_rsv  = restart ? '0 : row_start_vertex;
  assign c_cur  = restart ? '0 : current_vertex;
  assign c_fin  = restart ? 1'b0 : finished;

  assign cur_ls   = c_cur + cfg.line_step;
  assign rsv_ls   = c_rsv + cfg.line_step;
  assign cur_cs   = c_cur + cfg.column_step;
  assign cur_1    = c_cur + IDX_W'(1);
  assign cur_1_ls = cur_1 + cfg.line_step;

  assign col_end_strip = ({1'b0, c_cc} + 17'd1) >= {1'b0, cfg.columns};
  assign col_end_list  = ({1'b0, c_cc} + 17'd2) >= {1'b0, cfg.columns};
  assign row_end       = ({1'b0, c_rc} + 17'd2) >= {1'b0, cfg.rows};

  always_comb begin
    if (cfg.topology_mode == MODE_LIST) begin
      degenerate = (cfg.rows < 16'd2) || (cfg.columns < 16'd2);
    end else begin
      degenerate = (cfg.rows < 16'd2) || (cfg.columns < 16'd1);
    end
  end

  always_comb begin
    row_count_next        = c_rc;
    column_count_next     = c_cc;
    slot_next             = c_slot;
    row_start_vertex_next = c_rsv;
    current_vertex_next   = c_cur;
    finished_next         = c_fin;
    result.vertex_index   = '0;
    result.final_index    = 1'b0;
    result.exhausted      = 1'b0;
    if (degenerate || c_fin) begin
      result.exhausted = 1'b1;
    end else if (cfg.topology_mode == MODE_LIST) begin
      unique case (c_slot)
        SLOT_1:  result.vertex_index = cur_ls;
        SLOT_2:  result.vertex_index = cur_1;
        SLOT_3:  result.vertex_index = cur_1;
        SLOT_4:  result.vertex_index = cur_ls;
        SLOT_5:  result.vertex_index = cur_1_ls;
        default: result.vertex_index = c_cur;
      endcase
      unique case (c_slot)
        SLOT_1, SLOT_2, SLOT_3, SLOT_4: slot_next = c_slot + SLOT_W'(1);
        SLOT_5: begin
          slot_next = SLOT_0;
          if (col_end_list) begin
            row_start_vertex_next = rsv_ls;
            current_vertex_next   = rsv_ls;
            column_count_next     = '0;
            if (row_end) begin
              result.final_index = 1'b1;
              finished_next      = 1'b1;
            end else begin
              row_count_next = c_rc + IDX_W'(1);
            end
          end else begin
            current_vertex_next = cur_1;
            column_count_next   = c_cc + IDX_W'(1);
          end
        end
        default: slot_next = SLOT_1;
      endcase
    end else begin
      unique case (c_slot)
        SLOT_1: begin
          result.vertex_index = cur_ls;
          if (col_end_strip) begin
            row_start_vertex_next = rsv_ls;
            if (row_end) begin
              result.final_index = 1'b1;
              finished_next      = 1'b1;
              slot_next          = SLOT_0;
            end else begin
              slot_next = SLOT_2;
            end
          end else begin
            current_vertex_next = cur_cs;
            column_count_next   = c_cc + IDX_W'(1);
            slot_next           = SLOT_0;
          end
        end
        SLOT_2: begin
          // degenerate pair: last lower vertex of the old row
          result.vertex_index = cur_ls;
          slot_next           = SLOT_3;
        end
        SLOT_3: begin
          result.vertex_index = c_rsv;
          current_vertex_next = c_rsv;
          column_count_next   = '0;
          row_count_next      = c_rc + IDX_W'(1);
          slot_next           = SLOT_0;
        end
        default: begin
          result.vertex_index = c_cur;
          slot_next           = SLOT_1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count        <= '0;
      column_count     <= '0;
      slot             <= '0;
      row_start_vertex <= '0;
      current_vertex   <= '0;
      finished         <= 1'b0;
    end else if (step) begin
      row_count        <= row_count_next;
      column_count     <= column_count_next;
      slot             <= slot_next;
      row_start_vertex <= row_start_vertex_next;
      current_vertex   <= current_vertex_next;
      finished         <= finished_next;
    end
  end

endmodule

// ----- design/grid_mesh_index_generator_top.sv -----
// Grid mesh index generator: emits the vertex index sequence of a regular grid.
// Input queue: drive restart and raise push while full is low; each beat asks
// for one index (restart=1 starts the grid over and yields its first index).
// Result queue: while empty is low, vertex_index, final_index and exhausted
// hold the oldest result; raise pop to take it. Every request gives one result.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no requests are in flight. The line offset
// (row_step times row_stride) is formed by one multiplier at write time.
// The generator step moves each request from the input queue to the result queue;
// it holds while the input queue is empty or the result queue is full.
// Throughput: one index per cycle while it is not held, set by the registered counter
// update in the generator; both queues hold QUEUE_DEPTH beats.
// Reset: configuration returns to strip mode, 2 by 2 grid, column step 1,
// row step 1, row stride 2; the walk restarts at index zero; queues empty.
// When the receiver stalls, the result queue fills, the generator holds, and
// the input queue then raises full.
module grid_mesh_index_generator_top #(
  parameter int unsigned QUEUE_DEPTH = gmig_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            restart,
  output logic                            empty,
  input  logic                            pop,
  output logic [gmig_pkg::IDX_W-1:0]      vertex_index,
  output logic                            final_index,
  output logic                            exhausted,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gmig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmig_pkg::IDX_W-1:0]      cfg_data
);
  import gmig_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned RES_W = $bits(result_t);

  logic             topology_mode;
  logic [IDX_W-1:0] columns, rows, column_step, row_step, row_stride, line_step;
  logic [IDX_W-1:0] mul_a, mul_b, mul_lo;
  logic             cfg_wr;
  cfg_t             cfg;

  logic             q_in_valid, q_in_empty, q_restart, gen_in_pop;
  logic             gen_out_push, q_out_full;
  result_t          gen_result, q_result;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // keep the line offset current with either operand being written
  assign mul_a  = (cfg_index == REG_ROW_STEP)   ? cfg_data : row_step;
  assign mul_b  = (cfg_index == REG_ROW_STRIDE) ? cfg_data : row_stride;
  assign mul_lo = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      topology_mode <= MODE_STRIP;
      columns       <= 16'd2;
      rows          <= 16'd2;
      column_step   <= 16'd1;
      row_step      <= 16'd1;
      row_stride    <= 16'd2;
      line_step     <= 16'd2;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_TOPOLOGY:    topology_mode <= cfg_data[0];
        REG_COLUMNS:     columns       <= cfg_data;
        REG_ROWS:        rows          <= cfg_data;
        REG_COLUMN_STEP: column_step   <= cfg_data;
        REG_ROW_STEP: begin
          row_step  <= cfg_data;
          line_step <= mul_lo;
        end
        REG_ROW_STRIDE: begin
          row_stride <= cfg_data;
          line_step  <= mul_lo;
        end
        default: ;
      endcase
    end
  end

  assign cfg.topology_mode = topology_mode;
  assign cfg.columns       = columns;
  assign cfg.rows          = rows;
  assign cfg.column_step   = column_step;
  assign cfg.line_step     = line_step;

  gmig_fifo #(
    .WIDTH (1),
    .DEPTH (QUEUE_DEPTH)
  ) u_in_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (restart),
    .full    (full),
    .pop     (gen_in_pop),
    .rd_data (q_restart),
    .empty   (q_in_empty)
  );

  assign q_in_valid = !q_in_empty;

  gmig_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (q_in_valid),
    .restart   (q_restart),
    .in_pop    (gen_in_pop),
    .out_ready (!q_out_full),
    .out_push  (gen_out_push),
    .result    (gen_result)
  );

  gmig_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (gen_out_push),
    .wr_data (gen_result),
    .full    (q_out_full),
    .pop     (pop),
    .rd_data (q_result),
    .empty   (empty)
  );

  assign vertex_index = q_result.vertex_index;
  assign final_index  = q_result.final_index;
  assign exhausted    = q_result.exhausted;

  `ASSERT_IMP(a_exh_zero, clk, rst, !empty && exhausted, vertex_index == '0)
  `ASSERT_IMP(a_fin_not_exh, clk, rst, !empty && final_index, !exhausted)
  `ASSERT_IMP(a_line_step, clk, rst, 1'b1, line_step == IDX_W'(row_step * row_stride))
  `ASSERT_NEXT(a_gen_fed, clk, rst, gen_out_push && !pop, !empty)

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the grid mesh index generator
`timescale 1ns / 100ps

module tb_top;
  import gmig_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic restart = 1'b0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IDX_W-1:0] cfg_data = '0;
  logic full, empty, final_index, exhausted, cfg_ready;
  logic [IDX_W-1:0] vertex_index;

  // register image for the next round of writes
  logic [IDX_W-1:0] reg_plan [8];

  // shadow configuration and walk state
  logic             mode_cfg = MODE_STRIP;
  logic [IDX_W-1:0] cols_cfg = 16'd2;
  logic [IDX_W-1:0] rows_cfg = 16'd2;
  logic [IDX_W-1:0] col_step_cfg = 16'd1;
  logic [IDX_W-1:0] row_step_cfg = 16'd1;
  logic [IDX_W-1:0] row_stride_cfg = 16'd2;
  logic [IDX_W-1:0] walk_row = '0;
  logic [IDX_W-1:0] walk_col = '0;
  logic [SLOT_W-1:0] walk_slot = SLOT_0;
  logic [IDX_W-1:0] row_base = '0;
  logic [IDX_W-1:0] walk_vertex = '0;
  logic             walk_done = 1'b0;

  result_t pending_indices [$];
  int error_count = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int send_gap_max = 0;
  int pop_gap_max = 0;
  int pop_hold = 0;

  grid_mesh_index_generator_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .restart      (restart),
    .empty        (empty),
    .pop          (pop),
    .vertex_index (vertex_index),
    .final_index  (final_index),
    .exhausted    (exhausted),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // advances the walk by one request and returns the index it yields
  function automatic result_t next_vertex_index(input logic restart_req);
    result_t r;
    logic [IDX_W-1:0] line_ofs;
    logic no_grid;
    r = '0;
    line_ofs = row_step_cfg * row_stride_cfg;
    if (restart_req) begin
      walk_row = '0;
      walk_col = '0;
      walk_slot = SLOT_0;
      row_base = '0;
      walk_vertex = '0;
      walk_done = 1'b0;
    end
    if (mode_cfg == MODE_LIST) begin
      no_grid = (rows_cfg < 16'd2) || (cols_cfg < 16'd2);
    end else begin
      no_grid = (rows_cfg < 16'd2) || (cols_cfg < 16'd1);
    end
    if (no_grid || walk_done) begin
      r.exhausted = 1'b1;
    end else if (mode_cfg == MODE_LIST) begin
      case (walk_slot)
        SLOT_1, SLOT_4: r.vertex_index = walk_vertex + line_ofs;
        SLOT_2, SLOT_3: r.vertex_index = walk_vertex + 16'd1;
        SLOT_5: r.vertex_index = walk_vertex + 16'd1 + line_ofs;
        default: begin
          r.vertex_index = walk_vertex;
          walk_slot = SLOT_0;
        end
      endcase
      if (walk_slot == SLOT_5) begin
        walk_slot = SLOT_0;
        // last quad of the row: move to the next row or finish
        if (walk_col + 32'd2 >= cols_cfg) begin
          row_base = row_base + line_ofs;
          walk_vertex = row_base;
          walk_col = '0;
          if (walk_row + 32'd2 >= rows_cfg) begin
            r.final_index = 1'b1;
            walk_done = 1'b1;
          end else begin
            walk_row = walk_row + 16'd1;
          end
        end else begin
          walk_vertex = walk_vertex + 16'd1;
          walk_col = walk_col + 16'd1;
        end
      end else begin
        walk_slot = walk_slot + 3'd1;
      end
    end else begin
      case (walk_slot)
        SLOT_1: begin
          r.vertex_index = walk_vertex + line_ofs;
          if (walk_col + 32'd1 >= cols_cfg) begin
            row_base = row_base + line_ofs;
            if (walk_row + 32'd2 >= rows_cfg) begin
              r.final_index = 1'b1;
              walk_done = 1'b1;
              walk_slot = SLOT_0;
            end else begin
              walk_slot = SLOT_2;
            end
          end else begin
            walk_vertex = walk_vertex + col_step_cfg;
            walk_col = walk_col + 16'd1;
            walk_slot = SLOT_0;
          end
        end
        // degenerate pair joining two rows
        SLOT_2: begin
          r.vertex_index = walk_vertex + line_ofs;
          walk_slot = SLOT_3;
        end
        SLOT_3: begin
          walk_vertex = row_base;
          walk_col = '0;
          walk_row = walk_row + 16'd1;
          walk_slot = SLOT_0;
          r.vertex_index = row_base;
        end
        default: begin
          r.vertex_index = walk_vertex;
          walk_slot = SLOT_1;
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [IDX_W-1:0] got,
                                 input logic [IDX_W-1:0] want);
    if (error_count < 50) begin
      $display("mismatch on result %0d, %s: got %h expected %h", results_seen, what, got, want);
    end
    error_count++;
  endtask

  // monitor: shadow config writes, predict on accepted requests, check results
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      mode_cfg = MODE_STRIP;
      cols_cfg = 16'd2;
      rows_cfg = 16'd2;
      col_step_cfg = 16'd1;
      row_step_cfg = 16'd1;
      row_stride_cfg = 16'd2;
      walk_row = '0;
      walk_col = '0;
      walk_slot = SLOT_0;
      row_base = '0;
      walk_vertex = '0;
      walk_done = 1'b0;
      stall_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TOPOLOGY:    mode_cfg = cfg_data[0];
          REG_COLUMNS:     cols_cfg = cfg_data;
          REG_ROWS:        rows_cfg = cfg_data;
          REG_COLUMN_STEP: col_step_cfg = cfg_data;
          REG_ROW_STEP:    row_step_cfg = cfg_data;
          REG_ROW_STRIDE:  row_stride_cfg = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pending_indices.size() == 0) begin
          report_mismatch("result with nothing pending", vertex_index, '0);
        end else begin
          want = pending_indices.pop_front();
          if (vertex_index !== want.vertex_index)
            report_mismatch("vertex_index", vertex_index, want.vertex_index);
          if (final_index !== want.final_index)
            report_mismatch("final_index", 16'(final_index), 16'(want.final_index));
          if (exhausted !== want.exhausted)
            report_mismatch("exhausted", 16'(exhausted), 16'(want.exhausted));
        end
        results_seen++;
      end
      if (push && !full) pending_indices.push_back(next_vertex_index(restart));
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // result side: random wait before taking each beat
  always @(posedge clk) begin
    int wait_n;
    if (rst) begin
      pop <= 1'b0;
      pop_hold <= 0;
    end else if (pop && !empty) begin
      wait_n = $urandom_range(pop_gap_max, 0);
      pop <= (wait_n == 0);
      pop_hold <= wait_n;
    end else if (pop_hold > 1) begin
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      pop_hold <= 0;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_request(input logic restart_req);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    restart <= restart_req;
    do @(posedge clk); while (full);
  endtask

  task automatic request_indices(input int count);
    repeat (count) send_request(1'b0);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (pending_indices.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] mask);
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_data <= reg_plan[i];
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(input logic mode, input logic [IDX_W-1:0] cols, rows,
                          cstep, rstep, rstride);
    wait_drained();
    reg_plan[REG_TOPOLOGY] = {15'd0, mode};
    reg_plan[REG_COLUMNS] = cols;
    reg_plan[REG_ROWS] = rows;
    reg_plan[REG_COLUMN_STEP] = cstep;
    reg_plan[REG_ROW_STEP] = rstep;
    reg_plan[REG_ROW_STRIDE] = rstride;
    program_regs(8'h3f);
  endtask

  // reset configuration: 2x2 strip, four indices then exhaustion
  task automatic test_default_grid();
    request_indices(5);
    send_request(1'b1);
  endtask

  task automatic test_list_grid();
    set_grid(MODE_LIST, 16'd2, 16'd2, 16'd0, 16'd1, 16'd3);
    send_request(1'b1);
    request_indices(6);
  endtask

  // list walk left mid-quad, then strip mode picks up the stale slot
  task automatic test_mode_switch();
    set_grid(MODE_LIST, 16'd3, 16'd3, 16'd5, 16'd2, 16'd4);
    send_request(1'b1);
    request_indices(3);
    wait_drained();
    reg_plan[REG_TOPOLOGY] = {15'd0, MODE_STRIP};
    program_regs(8'h01);
    request_indices(2);
  endtask

  task automatic test_degenerate_grids();
    set_grid(MODE_STRIP, 16'd4, 16'd1, 16'd1, 16'd1, 16'd4);
    send_request(1'b1);
    set_grid(MODE_STRIP, 16'd0, 16'd3, 16'd1, 16'd1, 16'd4);
    send_request(1'b0);
    set_grid(MODE_LIST, 16'd1, 16'd3, 16'd1, 16'd1, 16'd4);
    send_request(1'b1);
    set_grid(MODE_LIST, 16'd3, 16'd0, 16'd1, 16'd1, 16'd4);
    send_request(1'b0);
  endtask

  // all-ones registers wrap the line offset to 1; spare indexes are ignored
  task automatic test_register_extremes();
    set_grid(MODE_STRIP, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    reg_plan[REG_SPARE_A] = 16'hffff;
    reg_plan[REG_SPARE_B] = 16'hffff;
    program_regs(8'hc0);
    send_request(1'b1);
    request_indices(3);
    wait_drained();
    reg_plan[REG_TOPOLOGY] = {15'd0, MODE_LIST};
    program_regs(8'h01);
    request_indices(2);
  endtask

  task automatic test_random_walks();
    int sent;
    int n_items;
    logic first_restart;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(2, 0))
        0: send_gap_max = 0;
        1: send_gap_max = 4;
        default: send_gap_max = 16;
      endcase
      case ($urandom_range(2, 0))
        0: pop_gap_max <= 0;
        1: pop_gap_max <= 4;
        default: pop_gap_max <= 16;
      endcase
      // mostly small grids so walks reach their end; now and then huge ones
      reg_plan[REG_TOPOLOGY] = 16'($urandom_range(1, 0));
      reg_plan[REG_COLUMNS] = ($urandom_range(7, 0) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(6, 0));
      reg_plan[REG_ROWS] = ($urandom_range(7, 0) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(5, 0));
      reg_plan[REG_COLUMN_STEP] = ($urandom_range(1, 0) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(3, 0));
      reg_plan[REG_ROW_STEP] = ($urandom_range(1, 0) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(3, 0));
      reg_plan[REG_ROW_STRIDE] = ($urandom_range(1, 0) == 0) ? 16'($urandom)
                                                              : 16'($urandom_range(8, 0));
      reg_plan[REG_SPARE_A] = 16'($urandom);
      reg_plan[REG_SPARE_B] = 16'($urandom);
      program_regs(8'($urandom));
      n_items = $urandom_range(60, 5);
      first_restart = ($urandom_range(4, 0) != 0);
      send_request(first_restart);
      for (int k = 1; k < n_items; k++) begin
        send_request($urandom_range(31, 0) == 0);
      end
      sent += n_items;
    end
  endtask

  initial begin
    send_gap_max = 3;
    pop_gap_max <= 3;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_grid();
    test_list_grid();
    test_mode_switch();
    test_degenerate_grids();
    test_register_extremes();
    test_random_walks();
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/gmig_pkg.sv
design/gmig_fifo.sv
design/gmig_gen.sv
design/grid_mesh_index_generator_top.sv
verif/tb_top.sv
